>>> sv/fva_pkg.sv
// Shared types, codes and float helpers for the binary32 vector ALU.
package fva_pkg;

	localparam int LANES = 4;
	localparam int LANE_LAT = 7;

	localparam logic [2:0] FN_AXPY  = 3'd0;
	localparam logic [2:0] FN_AXMY  = 3'd1;
	localparam logic [2:0] FN_ADD   = 3'd2;
	localparam logic [2:0] FN_SUB   = 3'd3;
	localparam logic [2:0] FN_SCALE = 3'd4;

	localparam logic [1:0] ADDR_SCALE = 2'd0;
	localparam logic [31:0] SCALE_RST = 32'h3F80_0000;
	localparam logic [31:0] QNAN = 32'h7FC0_0000;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] x_lane0;
		logic [31:0] x_lane1;
		logic [31:0] x_lane2;
		logic [31:0] x_lane3;
		logic [31:0] y_lane0;
		logic [31:0] y_lane1;
		logic [31:0] y_lane2;
		logic [31:0] y_lane3;
		logic        last_in;
	} in_word_t;

	typedef struct packed {
		logic [31:0] r_lane0;
		logic [31:0] r_lane1;
		logic [31:0] r_lane2;
		logic [31:0] r_lane3;
		logic        last_out;
	} out_word_t;

	typedef struct packed {
		logic use_mul;
		logic use_add;
		logic neg_y;
		logic zero_out;
	} ctl_t;

	function automatic logic is_nan(input logic [31:0] v);
		return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
	endfunction

	function automatic logic is_inf(input logic [31:0] v);
		return (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
	endfunction

	function automatic logic is_zero(input logic [31:0] v);
		return v[30:0] == 31'd0;
	endfunction

	function automatic logic [5:0] lzc48(input logic [47:0] v);
		logic [5:0] n;
		n = 6'd48;
		for (int i = 0; i < 48; i++) begin
			if (v[i]) n = 6'(47 - i);
		end
		return n;
	endfunction

	// m[25:2] kept bits, m[1] guard, m[0] sticky; be is the biased exponent of m[25]
	function automatic logic [31:0] round_pack(input logic sgn, input logic signed [9:0] be,
			input logic [25:0] m);
		logic [4:0]  sh;
		logic [25:0] mask;
		logic [25:0] ms;
		logic        lost;
		logic        up;
		logic [24:0] kept;
		logic signed [9:0] bex;
		logic [22:0] mant;
		if (be < 10'sd1) begin
			if (be < -10'sd24) sh = 5'd26;
			else sh = 5'(10'sd1 - be);
		end else begin
			sh = 5'd0;
		end
		mask = (26'd1 << sh) - 26'd1;
		lost = |(m & mask);
		ms = m >> sh;
		ms[0] = ms[0] | lost;
		up = ms[1] & (ms[0] | ms[2]);
		kept = {1'b0, ms[25:2]} + {24'd0, up};
		if (be < 10'sd1) return {sgn, 7'd0, kept[23:0]};
		bex = kept[24] ? be + 10'sd1 : be;
		mant = kept[24] ? 23'd0 : kept[22:0];
		if (bex >= 10'sd255) return {sgn, 8'hFF, 23'd0};
		return {sgn, bex[7:0], mant};
	endfunction

endpackage

>>> sv/fva_fmul.sv
// Three-stage binary32 multiplier: product, normalise, round.
module fva_fmul (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] r
);

	logic        sgn;
	logic        spec;
	logic [31:0] specv;
	logic [7:0]  ea, eb;

	logic        sgn_s1, spec_s1;
	logic [31:0] specv_s1;
	logic signed [9:0] e_s1;
	logic [47:0] p_s1;

	logic [5:0]  lz;
	logic [47:0] pn;

	logic        sgn_s2, spec_s2;
	logic [31:0] specv_s2;
	logic signed [9:0] be_s2;
	logic [25:0] m_s2;

	logic [31:0] r_s3;

	always_comb begin
		sgn = a[31] ^ b[31];
		spec = 1'b1;
		specv = {sgn, 31'd0};
		if (fva_pkg::is_nan(a) || fva_pkg::is_nan(b)) begin
			specv = fva_pkg::QNAN;
		end else if (fva_pkg::is_inf(a) || fva_pkg::is_inf(b)) begin
			specv = (fva_pkg::is_zero(a) || fva_pkg::is_zero(b)) ? fva_pkg::QNAN
				: {sgn, 8'hFF, 23'd0};
		end else if (!(fva_pkg::is_zero(a) || fva_pkg::is_zero(b))) begin
			spec = 1'b0;
		end
		ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s1 <= sgn;
			spec_s1 <= spec;
			specv_s1 <= specv;
			e_s1 <= $signed({2'b00, ea}) + $signed({2'b00, eb}) - 10'sd300;
			p_s1 <= {24'd0, (a[30:23] != 8'd0), a[22:0]} * {24'd0, (b[30:23] != 8'd0), b[22:0]};
		end
	end

	assign lz = fva_pkg::lzc48(p_s1);
	assign pn = p_s1 << lz;

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s2 <= sgn_s1;
			spec_s2 <= spec_s1;
			specv_s2 <= specv_s1;
			be_s2 <= e_s1 + 10'sd174 - $signed({4'd0, lz});
			m_s2 <= {pn[47:23], |pn[22:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s3 <= spec_s2 ? specv_s2 : fva_pkg::round_pack(sgn_s2, be_s2, m_s2);
		end
	end

	assign r = r_s3;

endmodule

>>> sv/fva_fadd.sv
// Four-stage binary32 adder: align, add, normalise, round; with a bypass value.
module fva_fadd (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic        pass,
	input  logic [31:0] pass_val,
	output logic [31:0] r
);

	logic        spec;
	logic [31:0] specv;
	logic        swap;
	logic [31:0] big, sml;
	logic [7:0]  exb, exs, d;
	logic [26:0] bfull, bsh, bmask;
	logic [4:0]  dsh;

	logic        sgn_s1, sub_s1, spec_s1;
	logic [31:0] specv_s1;
	logic [7:0]  exp_s1;
	logic [26:0] a_s1, b_s1;

	logic        sgn_s2, spec_s2;
	logic [31:0] specv_s2;
	logic [7:0]  exp_s2;
	logic [27:0] sum_s2;

	logic [5:0]  lz;
	logic [47:0] sn;

	logic        sgn_s3, spec_s3, zero_s3;
	logic [31:0] specv_s3;
	logic signed [9:0] be_s3;
	logic [25:0] m_s3;

	logic [31:0] r_s4;

	always_comb begin
		spec = 1'b1;
		specv = a;
		if (pass) begin
			specv = pass_val;
		end else if (fva_pkg::is_nan(a) || fva_pkg::is_nan(b)) begin
			specv = fva_pkg::QNAN;
		end else if (fva_pkg::is_inf(a) && fva_pkg::is_inf(b)) begin
			specv = (a[31] ^ b[31]) ? fva_pkg::QNAN : a;
		end else if (fva_pkg::is_inf(a)) begin
			specv = a;
		end else if (fva_pkg::is_inf(b)) begin
			specv = b;
		end else if (fva_pkg::is_zero(a) && fva_pkg::is_zero(b)) begin
			specv = a & b;
		end else if (fva_pkg::is_zero(a)) begin
			specv = b;
		end else if (fva_pkg::is_zero(b)) begin
			specv = a;
		end else begin
			spec = 1'b0;
		end
		swap = b[30:0] > a[30:0];
		big = swap ? b : a;
		sml = swap ? a : b;
		exb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		exs = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		d = exb - exs;
		dsh = (d > 8'd26) ? 5'd27 : d[4:0];
		bfull = {(sml[30:23] != 8'd0), sml[22:0], 3'b000};
		bmask = (27'd1 << dsh) - 27'd1;
		// fold shifted-out bits into the sticky bit
		bsh = (bfull >> dsh) | {26'd0, |(bfull & bmask)};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s1 <= big[31];
			sub_s1 <= a[31] ^ b[31];
			spec_s1 <= spec;
			specv_s1 <= specv;
			exp_s1 <= exb;
			a_s1 <= {(big[30:23] != 8'd0), big[22:0], 3'b000};
			b_s1 <= bsh;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s2 <= sgn_s1;
			spec_s2 <= spec_s1;
			specv_s2 <= specv_s1;
			exp_s2 <= exp_s1;
			sum_s2 <= sub_s1 ? {1'b0, a_s1} - {1'b0, b_s1} : {1'b0, a_s1} + {1'b0, b_s1};
		end
	end

	assign lz = fva_pkg::lzc48({sum_s2, 20'd0});
	assign sn = {sum_s2, 20'd0} << lz;

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s3 <= sgn_s2;
			spec_s3 <= spec_s2;
			specv_s3 <= specv_s2;
			zero_s3 <= sum_s2 == 28'd0;
			be_s3 <= $signed({2'b00, exp_s2}) + 10'sd1 - $signed({4'd0, lz});
			m_s3 <= {sn[47:23], |sn[22:20]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (spec_s3) r_s4 <= specv_s3;
			else if (zero_s3) r_s4 <= 32'd0;
			else r_s4 <= fva_pkg::round_pack(sgn_s3, be_s3, m_s3);
		end
	end

	assign r = r_s4;

endmodule

>>> sv/fva_lane.sv
// One lane: scaled multiply followed by the add/subtract, with operand selection.
module fva_lane (
	input  logic         clk,
	input  logic         en,
	input  fva_pkg::ctl_t ctl,
	input  logic [31:0]  scale,
	input  logic [31:0]  x,
	input  logic [31:0]  y,
	output logic [31:0]  r
);

	logic [31:0] prod;
	fva_pkg::ctl_t ctl_s1, ctl_s2, ctl_s3;
	logic [31:0] x_s1, x_s2, x_s3;
	logic [31:0] y_s1, y_s2, y_s3;
	logic [31:0] op_a, op_b, pv;

	fva_fmul u_mul (
		.clk(clk),
		.en (en),
		.a  (scale),
		.b  (x),
		.r  (prod)
	);

	// hold x, y and control alongside the multiplier
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			x_s1 <= x;
			x_s2 <= x_s1;
			x_s3 <= x_s2;
			y_s1 <= y;
			y_s2 <= y_s1;
			y_s3 <= y_s2;
		end
	end

	assign op_a = ctl_s3.use_mul ? prod : x_s3;
	assign op_b = {y_s3[31] ^ ctl_s3.neg_y, y_s3[30:0]};
	assign pv = ctl_s3.zero_out ? 32'd0 : prod;

	fva_fadd u_add (
		.clk     (clk),
		.en      (en),
		.a       (op_a),
		.b       (op_b),
		.pass    (!ctl_s3.use_add),
		.pass_val(pv),
		.r       (r)
	);

endmodule

>>> sv/float_vector_axpy_alu.sv
// Pipeline: 7 lane stages, then 1 merge register, between input word and result word.
// Throughput: one word per cycle; the pipeline holds as a whole while a result waits.
// Each lane runs its own multiplier and adder; the merge register gathers all lanes.
// Reset: arst_n clears the valid pipeline and sets scale_q to 1.0.
// Per word: r = a*x+y, a*x-y, x+y, x-y, a*x, or 0 for other codes, on each of four binary32 lanes.
module float_vector_axpy_alu (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  fva_pkg::in_word_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output fva_pkg::out_word_t  out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [1:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int PIPE = fva_pkg::LANE_LAT + 1;

	logic [31:0] scale_q;
	logic [PIPE-1:0] vld_q;
	logic [fva_pkg::LANE_LAT-1:0] last_q;
	logic en;
	fva_pkg::ctl_t ctl;
	logic [31:0] x_a [fva_pkg::LANES];
	logic [31:0] y_a [fva_pkg::LANES];
	logic [31:0] r_a [fva_pkg::LANES];
	fva_pkg::out_word_t out_q;

	assign pready = 1'b1;
	assign prdata = (paddr == fva_pkg::ADDR_SCALE) ? scale_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= fva_pkg::SCALE_RST;
		end else if (psel && penable && pwrite && pready) begin
			scale_q <= pwdata;
		end
	end

	always_comb begin
		ctl = '0;
		unique case (in_data.func)
			fva_pkg::FN_AXPY:  ctl = '{use_mul: 1'b1, use_add: 1'b1, neg_y: 1'b0, zero_out: 1'b0};
			fva_pkg::FN_AXMY:  ctl = '{use_mul: 1'b1, use_add: 1'b1, neg_y: 1'b1, zero_out: 1'b0};
			fva_pkg::FN_ADD:   ctl = '{use_mul: 1'b0, use_add: 1'b1, neg_y: 1'b0, zero_out: 1'b0};
			fva_pkg::FN_SUB:   ctl = '{use_mul: 1'b0, use_add: 1'b1, neg_y: 1'b1, zero_out: 1'b0};
			fva_pkg::FN_SCALE: ctl = '{use_mul: 1'b1, use_add: 1'b0, neg_y: 1'b0, zero_out: 1'b0};
			default:           ctl = '{use_mul: 1'b1, use_add: 1'b0, neg_y: 1'b0, zero_out: 1'b1};
		endcase
	end

	assign x_a[0] = in_data.x_lane0;
	assign x_a[1] = in_data.x_lane1;
	assign x_a[2] = in_data.x_lane2;
	assign x_a[3] = in_data.x_lane3;
	assign y_a[0] = in_data.y_lane0;
	assign y_a[1] = in_data.y_lane1;
	assign y_a[2] = in_data.y_lane2;
	assign y_a[3] = in_data.y_lane3;

	// advance everything unless the finished word is still waiting
	assign en = !vld_q[PIPE-1] || out_ready;
	assign in_ready = en;

	for (genvar g = 0; g < fva_pkg::LANES; g++) begin : g_lane
		fva_lane u_lane (
			.clk  (clk),
			.en   (en),
			.ctl  (ctl),
			.scale(scale_q),
			.x    (x_a[g]),
			.y    (y_a[g]),
			.r    (r_a[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_q <= {last_q[fva_pkg::LANE_LAT-2:0], in_data.last_in};
			out_q.r_lane0 <= r_a[0];
			out_q.r_lane1 <= r_a[1];
			out_q.r_lane2 <= r_a[2];
			out_q.r_lane3 <= r_a[3];
			out_q.last_out <= last_q[fva_pkg::LANE_LAT-1];
		end
	end

	assign out_valid = vld_q[PIPE-1];
	assign out_data = out_q;

`ifndef SYNTHESIS
	a_nan_canon: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !((fva_pkg::is_nan(out_data.r_lane0) && out_data.r_lane0 != fva_pkg::QNAN)
			|| (fva_pkg::is_nan(out_data.r_lane1) && out_data.r_lane1 != fva_pkg::QNAN)
			|| (fva_pkg::is_nan(out_data.r_lane2) && out_data.r_lane2 != fva_pkg::QNAN)
			|| (fva_pkg::is_nan(out_data.r_lane3) && out_data.r_lane3 != fva_pkg::QNAN)))
		else $error("non-canonical NaN in result word");
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(vld_q))
		else $error("pipeline moved while result word stalled");
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite) |=> scale_q == $past(pwdata))
		else $error("scale register not written");
`endif

endmodule

>>> tb/float_vector_axpy_alu_check.sv
// Result checker for the binary32 vector ALU: predicts each lane and compares.
module float_vector_axpy_alu_check (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  fva_pkg::in_word_t   in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  fva_pkg::out_word_t  out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [1:0]          paddr,
	input  logic [31:0]         pwdata,
	input  logic                pready,
	output int                  fail_count,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import fva_pkg::*;

	localparam logic [31:0] PINF = 32'h7F80_0000;
	localparam logic [31:0] SGN  = 32'h8000_0000;

	logic [31:0] scale_a;
	out_word_t   result_queue[$];

	function automatic bit f_nan(logic [31:0] v);
		return v[30:0] > PINF[30:0];
	endfunction

	function automatic bit f_inf(logic [31:0] v);
		return v[30:0] == PINF[30:0];
	endfunction

	function automatic bit f_zero(logic [31:0] v);
		return v[30:0] == 31'd0;
	endfunction

	// value = sig * 2^e exactly
	function automatic void unpack_f(logic [31:0] v, output logic [63:0] sig,
			output int e);
		if (v[30:23] == 8'd0) begin
			sig = {41'd0, v[22:0]};
			e = -149;
		end else begin
			sig = {40'd0, 1'b1, v[22:0]};
			e = int'(v[30:23]) - 150;
		end
	endfunction

	// round sig*2^e to nearest even; bit 0 of sig may carry sticky
	function automatic logic [31:0] round_f(logic [31:0] sgn, int e, logic [63:0] sig);
		int bexp;
		int sh;
		logic [63:0] kept;
		logic [63:0] rem;
		logic [63:0] half;
		if (sig == 64'd0) return sgn;
		while (!sig[63]) begin
			sig = sig << 1;
			e--;
		end
		bexp = e + 63 + 127;
		sh = 40;
		if (bexp < 1) sh = 40 + (1 - bexp);
		if (sh > 64) return sgn;
		if (sh == 64) begin
			kept = 64'd0;
			rem = sig;
			half = 64'h8000_0000_0000_0000;
		end else begin
			kept = sig >> sh;
			rem = sig & ((64'd1 << sh) - 64'd1);
			half = 64'd1 << (sh - 1);
		end
		if (rem > half || (rem == half && kept[0])) kept++;
		if (bexp < 1) return sgn | kept[31:0];
		if (kept[24]) begin
			kept = kept >> 1;
			bexp++;
		end
		if (bexp >= 255) return sgn | PINF;
		return sgn | (32'(bexp) << 23) | {9'd0, kept[22:0]};
	endfunction

	function automatic logic [31:0] mul_f(logic [31:0] a, logic [31:0] b);
		logic [31:0] s;
		logic [63:0] sa, sb;
		int ea, eb;
		s = (a ^ b) & SGN;
		if (f_nan(a) || f_nan(b)) return QNAN;
		if (f_inf(a) || f_inf(b)) begin
			if (f_zero(a) || f_zero(b)) return QNAN;
			return s | PINF;
		end
		if (f_zero(a) || f_zero(b)) return s;
		unpack_f(a, sa, ea);
		unpack_f(b, sb, eb);
		return round_f(s, ea + eb, sa * sb);
	endfunction

	function automatic logic [31:0] add_f(logic [31:0] a, logic [31:0] b);
		logic [63:0] sa, sb, t;
		int ea, eb, ti, d;
		logic [31:0] ga, gb, tg;
		if (f_nan(a) || f_nan(b)) return QNAN;
		if (f_inf(a) && f_inf(b)) return ((a ^ b) & SGN) != 0 ? QNAN : a;
		if (f_inf(a)) return a;
		if (f_inf(b)) return b;
		if (f_zero(a) && f_zero(b)) return a & b;
		if (f_zero(a)) return b;
		if (f_zero(b)) return a;
		unpack_f(a, sa, ea);
		unpack_f(b, sb, eb);
		ga = a & SGN;
		gb = b & SGN;
		sa = sa << 38;
		ea -= 38;
		sb = sb << 38;
		eb -= 38;
		if (ea < eb) begin
			t = sa; sa = sb; sb = t;
			ti = ea; ea = eb; eb = ti;
			tg = ga; ga = gb; gb = tg;
		end
		d = ea - eb;
		if (d >= 63) sb = 64'd1;
		else if (d > 0) sb = (sb >> d) | 64'((sb & ((64'd1 << d) - 64'd1)) != 0);
		if (ga == gb) return round_f(ga, ea, sa + sb);
		if (sa == sb) return 32'd0;
		if (sa > sb) return round_f(ga, ea, sa - sb);
		return round_f(gb, ea, sb - sa);
	endfunction

	function automatic logic [31:0] lane_op(logic [2:0] fn, logic [31:0] x, logic [31:0] y);
		case (fn)
			FN_AXPY:  return add_f(mul_f(scale_a, x), y);
			FN_AXMY:  return add_f(mul_f(scale_a, x), y ^ SGN);
			FN_ADD:   return add_f(x, y);
			FN_SUB:   return add_f(x, y ^ SGN);
			FN_SCALE: return mul_f(scale_a, x);
			default:  return 32'd0;
		endcase
	endfunction

	function automatic out_word_t compute_lanes(in_word_t w);
		out_word_t r;
		r.r_lane0 = lane_op(w.func, w.x_lane0, w.y_lane0);
		r.r_lane1 = lane_op(w.func, w.x_lane1, w.y_lane1);
		r.r_lane2 = lane_op(w.func, w.x_lane2, w.y_lane2);
		r.r_lane3 = lane_op(w.func, w.x_lane3, w.y_lane3);
		r.last_out = w.last_in;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s got %h want %h", $realtime, what, got, want);
		fail_count++;
	endtask

	initial fail_count = 0;
	assign pending = result_queue.size();

	always @(posedge clk or negedge arst_n) begin
		out_word_t e;
		if (!arst_n) begin
			scale_a <= SCALE_RST;
		end else begin
			if (psel && penable && pwrite && pready && paddr == ADDR_SCALE)
				scale_a <= pwdata;
			if (in_valid && in_ready)
				result_queue.push_back(compute_lanes(in_data));
			if (out_valid && out_ready) begin
				if (result_queue.size() == 0) begin
					report_mismatch("unexpected word lane0", out_data.r_lane0, 32'd0);
				end else begin
					e = result_queue.pop_front();
					if (out_data.r_lane0 !== e.r_lane0)
						report_mismatch("lane0", out_data.r_lane0, e.r_lane0);
					if (out_data.r_lane1 !== e.r_lane1)
						report_mismatch("lane1", out_data.r_lane1, e.r_lane1);
					if (out_data.r_lane2 !== e.r_lane2)
						report_mismatch("lane2", out_data.r_lane2, e.r_lane2);
					if (out_data.r_lane3 !== e.r_lane3)
						report_mismatch("lane3", out_data.r_lane3, e.r_lane3);
					if (out_data.last_out !== e.last_out)
						report_mismatch("last_out", 32'(out_data.last_out),
							32'(e.last_out));
				end
			end
		end
	end

endmodule

>>> tb/float_vector_axpy_alu_test.sv
// Top of the vector ALU testbench: clock, reset, stimulus and verdict.
module float_vector_axpy_alu_test;
	timeunit 1ns;
	timeprecision 1ps;
	import fva_pkg::*;

	localparam int IDLE_PCT = 27;
	localparam int WATCHDOG = 20000;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	in_word_t in_data;
	out_word_t out_data;
	logic psel, penable, pwrite, pready;
	logic [1:0] paddr;
	logic [31:0] pwdata, prdata;
	int fail_count, pending;
	bit calm, hold_off;
	int quiet_cycles;

	float_vector_axpy_alu u_dut (.*);

	float_vector_axpy_alu_check u_check (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver: random stalls, or a long hold-off when asked
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) out_ready <= 1'b0;
			else out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic write_scale(logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_SCALE;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_word(in_word_t w);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_float();
		case ($urandom_range(9))
			0: return {1'($urandom_range(1)), 8'hFF, 23'd0};
			1: return {1'($urandom_range(1)), 8'hFF, 23'($urandom)};
			2: return {1'($urandom_range(1)), 8'd0, 23'($urandom)};
			3: return {1'($urandom_range(1)), 31'd0};
			4: return {1'($urandom_range(1)), 8'($urandom_range(250, 254)), 23'($urandom)};
			5: return {1'($urandom_range(1)), 8'($urandom_range(1, 20)), 23'($urandom)};
			default: return {1'($urandom_range(1)), 8'($urandom_range(100, 154)),
				23'($urandom)};
		endcase
	endfunction

	function automatic in_word_t rand_word(bit any_code);
		in_word_t w;
		w.func = any_code && $urandom_range(9) == 0 ? 3'($urandom_range(5, 7))
			: 3'($urandom_range(FN_SCALE));
		w.x_lane0 = pick_float();
		w.x_lane1 = pick_float();
		w.x_lane2 = $urandom_range(3) == 0 ? $urandom : pick_float();
		w.x_lane3 = pick_float();
		w.y_lane0 = pick_float();
		w.y_lane1 = pick_float();
		w.y_lane2 = $urandom_range(3) == 0 ? $urandom : pick_float();
		w.y_lane3 = pick_float();
		w.last_in = $urandom_range(5) == 0;
		return w;
	endfunction

	initial begin
		logic [31:0] scales[6];
		logic [31:0] xs[8];
		logic [31:0] ys[8];
		in_word_t w;
		scales = '{32'h3F80_0000, 32'h0000_0000, 32'hFF7F_FFFF, 32'h0000_0001,
			32'h7F80_0000, 32'hC040_0000};
		xs = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
			32'h7FC0_0001, 32'h7F7F_FFFF, 32'h0000_0001, 32'h3F80_0000};
		ys = '{32'h8000_0000, 32'h8000_0000, 32'hFF80_0000, 32'hFF80_0000,
			32'h3F80_0000, 32'h7F7F_FFFF, 32'h8000_0001, 32'hBF80_0000};
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		calm = 1'b0;
		hold_off = 1'b0;
		quiet_cycles = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words at reset scale: zeros, infinities, NaN, overflow, cancel
		for (int i = 0; i < 16; i++) begin
			w.func = 3'(i % 8);
			w.x_lane0 = xs[i % 8];
			w.x_lane1 = xs[(i + 3) % 8];
			w.x_lane2 = xs[(i + 5) % 8];
			w.x_lane3 = 32'hFFFF_FFFF;
			w.y_lane0 = ys[i % 8];
			w.y_lane1 = ys[(i + 3) % 8];
			w.y_lane2 = xs[(i + 5) % 8];
			w.y_lane3 = 32'h0000_0000;
			w.last_in = i[0];
			send_word(w);
		end
		drain();

		for (int p = 0; p < 6; p++) begin
			write_scale(p == 5 ? $urandom : scales[p]);
			calm = (p == 2);
			for (int n = 0; n < 300; n++) begin
				if (p == 3 && n == 50) begin
					hold_off = 1'b1;
					fork
						begin
							repeat (60) @(posedge clk);
							hold_off = 1'b0;
						end
					join_none
				end
				if (p == 4 && n == 100) drain();
				send_word(rand_word(1'b1));
			end
			drain();
		end
		calm = 1'b0;
		if (fail_count == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule
